// ----- sv/ssm_pkg.sv -----
// Shared types and constants for the serial seven-segment display multiplexer.
package ssm_pkg;

  localparam int unsigned MAX_DISPLAYS = 4;
  localparam int unsigned IDX_W        = $clog2(MAX_DISPLAYS);
  localparam int unsigned SEARCH_STEPS = 12;

  localparam logic [3:0] GLYPH_DOT_ROUND = 4'd10;
  localparam logic [3:0] GLYPH_BLANK     = 4'd15;
  localparam logic [3:0] DIGIT_LIMIT     = 4'd10;
  localparam logic [2:0] FRAME_LAST_BIT  = 3'd4;
  localparam logic [7:0] TIMEOUT_RESET   = 8'd3;

  typedef logic [MAX_DISPLAYS-1:0][3:0] digits_t;

  // Digit store after reset: entry 0 is 1, then 8, 2, 1.
  localparam digits_t DIGITS_RESET = {4'd1, 4'd2, 4'd8, 4'd1};

  typedef struct packed {
    digits_t     digits;
    logic [3:0]  dot_bits;
  } disp_t;

  typedef struct packed {
    logic [3:0] glyph;
    logic [3:0] display_mask;
    logic       dot_round;
  } result_t;

  typedef enum logic {
    SCAN_IDLE,
    SCAN_RUN
  } scan_state_e;

endpackage

// ----- sv/ssm_if.sv -----
// Valid/ready channel interfaces for input items and result words.
interface ssm_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic data_bit;

  modport source (output valid, output mode, output data_bit, input ready);
  modport sink   (input valid, input mode, input data_bit, output ready);
endinterface

interface ssm_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] glyph;
  logic [3:0] display_mask;
  logic       dot_round;

  modport source (output valid, output glyph, output display_mask, output dot_round,
                  input ready);
  modport sink   (input valid, input glyph, input display_mask, input dot_round,
                  output ready);
endinterface

// ----- sv/ssm_receiver.sv -----
// Serial frame receiver: gathers 5-bit frames into the digit store and dot mask.
module ssm_receiver #(
  parameter int unsigned NUM_DISPLAYS = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          edge_en_i,
  input  logic          tick_en_i,
  input  logic          data_bit_i,
  input  logic [7:0]    timeout_i,
  output logic          receiving_o,
  output ssm_pkg::disp_t disp_o
);
  import ssm_pkg::*;

  logic       recv_q, recv_d;
  logic [4:0] frame_q, frame_d;
  logic [2:0] bitpos_q, bitpos_d;
  logic [2:0] count_q, count_d;
  logic [7:0] ticks_q, ticks_d;
  digits_t    digits_q, digits_d;
  logic [3:0] dot_q, dot_d;
  logic [4:0] frame_new;
  logic [7:0] ticks_dec;

  assign frame_new = frame_q | (5'(data_bit_i) << bitpos_q);
  assign ticks_dec = ticks_q - 8'd1;

  always_comb begin
    recv_d   = recv_q;
    frame_d  = frame_q;
    bitpos_d = bitpos_q;
    count_d  = count_q;
    ticks_d  = ticks_q;
    digits_d = digits_q;
    dot_d    = dot_q;
    if (edge_en_i) begin
      if (!recv_q) begin
        // opening edge: data bit ignored
        recv_d   = 1'b1;
        ticks_d  = timeout_i;
        count_d  = '0;
        dot_d    = '0;
        bitpos_d = '0;
        frame_d  = '0;
      end else begin
        ticks_d = timeout_i;
        if (bitpos_q == FRAME_LAST_BIT) begin
          frame_d  = '0;
          bitpos_d = '0;
          if (frame_new[4]) begin
            dot_d[count_q[IDX_W-1:0]] = 1'b1;
          end
          // drop values of ten or more
          if (frame_new[3:0] < DIGIT_LIMIT) begin
            digits_d[count_q[IDX_W-1:0]] = frame_new[3:0];
            count_d = count_q + 3'd1;
          end
          if (count_d >= 3'(NUM_DISPLAYS)) begin
            recv_d  = 1'b0;
            ticks_d = '0;
          end
        end else begin
          frame_d  = frame_new;
          bitpos_d = bitpos_q + 3'd1;
        end
      end
    end else if (tick_en_i) begin
      ticks_d = ticks_dec;
      if (ticks_dec == 8'd0) begin
        recv_d = 1'b0;
        dot_d  = 4'b0001;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recv_q   <= 1'b0;
      frame_q  <= '0;
      bitpos_q <= '0;
      count_q  <= '0;
      ticks_q  <= '0;
      digits_q <= DIGITS_RESET;
      dot_q    <= '0;
    end else begin
      recv_q   <= recv_d;
      frame_q  <= frame_d;
      bitpos_q <= bitpos_d;
      count_q  <= count_d;
      ticks_q  <= ticks_d;
      digits_q <= digits_d;
      dot_q    <= dot_d;
    end
  end

  assign receiving_o     = recv_q;
  assign disp_o.digits   = digits_q;
  assign disp_o.dot_bits = dot_q;

endmodule

// ----- sv/ssm_scan.sv -----
// Glyph search: steps a shared compare unit one glyph per cycle unless stalled.
module ssm_scan #(
  parameter int unsigned NUM_DISPLAYS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  ssm_pkg::disp_t   disp_i,
  output logic             busy_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ssm_pkg::result_t out_res_o
);
  import ssm_pkg::*;

  scan_state_e state_q, state_d;
  logic [3:0]  cursor_q, cursor_d;
  logic [3:0]  step_q, step_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_res_q, out_res_d;

  logic [3:0]  mask;
  logic        hit;
  logic        slot_free;
  logic [3:0]  cursor_next;
  result_t     cand;

  // Shared compare unit: match the cursor glyph against every display.
  always_comb begin
    mask = '0;
    for (int i = 0; i < int'(NUM_DISPLAYS); i++) begin
      if (disp_i.digits[i] == cursor_q) begin
        mask = mask | (4'd1 << (NUM_DISPLAYS - 1 - i));
      end
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  // Step outputs
  always_comb begin
    if (cursor_q >= GLYPH_DOT_ROUND) begin
      hit               = disp_i.dot_bits != 4'd0;
      cand.glyph        = GLYPH_BLANK;
      cand.display_mask = disp_i.dot_bits;
      cand.dot_round    = 1'b1;
      cursor_next       = '0;
    end else begin
      hit               = mask != 4'd0;
      cand.glyph        = cursor_q;
      cand.display_mask = mask;
      cand.dot_round    = 1'b0;
      cursor_next       = cursor_q + 4'd1;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SCAN_IDLE: begin
        if (start_i) state_d = SCAN_RUN;
      end
      SCAN_RUN: begin
        if (hit) begin
          if (slot_free) state_d = SCAN_IDLE;
        end else if (step_q == 4'(SEARCH_STEPS - 1)) begin
          state_d = SCAN_IDLE;
        end
      end
      default: state_d = SCAN_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    cursor_d    = cursor_q;
    step_d      = step_q;
    out_res_d   = out_res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      SCAN_IDLE: begin
        step_d = '0;
      end
      SCAN_RUN: begin
        if (hit) begin
          // hold the step until the output register frees up
          if (slot_free) begin
            cursor_d    = cursor_next;
            out_res_d   = cand;
            out_valid_d = 1'b1;
          end
        end else begin
          cursor_d = cursor_next;
          step_d   = step_q + 4'd1;
        end
      end
      default: step_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SCAN_IDLE;
      cursor_q    <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign busy_o      = state_q != SCAN_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ----- sv/seven_segment_serial_multiplexer.sv -----
// A serial edge or a tick during reception updates the receiver and gives no word.
// A tick outside reception starts the glyph search, one glyph per cycle through the
// compare unit unless a hit waits on a full output register; the word then lands in the
// output register, later while a previous word still waits on out ready.
// Input ready is low while the search runs, so no new item is taken until it ends.
// Reset: timeout 3, digit store 1 8 2 1, dot mask clear, glyph cursor at 0, idle.
module seven_segment_serial_multiplexer #(
  parameter int unsigned NUM_DISPLAYS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  ssm_in_if.sink     in_i,
  ssm_out_if.source  out_o
);
  import ssm_pkg::*;

  logic [7:0] timeout_q;
  logic       in_fire;
  logic       receiving;
  logic       busy;
  logic       edge_en, tick_recv_en, scan_start;
  logic       out_valid;
  disp_t      disp;
  result_t    out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready   = !busy;
  assign in_fire      = in_i.valid && !busy;
  assign edge_en      = in_fire && !in_i.mode;
  assign tick_recv_en = in_fire && in_i.mode && receiving;
  assign scan_start   = in_fire && in_i.mode && !receiving;

  ssm_receiver #(
    .NUM_DISPLAYS(NUM_DISPLAYS)
  ) u_receiver (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .edge_en_i  (edge_en),
    .tick_en_i  (tick_recv_en),
    .data_bit_i (in_i.data_bit),
    .timeout_i  (timeout_q),
    .receiving_o(receiving),
    .disp_o     (disp)
  );

  ssm_scan #(
    .NUM_DISPLAYS(NUM_DISPLAYS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .disp_i     (disp),
    .busy_o     (busy),
    .out_valid_o(out_valid),
    .out_ready_i(out_o.ready),
    .out_res_o  (out_res)
  );

  assign out_o.valid        = out_valid;
  assign out_o.glyph        = out_res.glyph;
  assign out_o.display_mask = out_res.display_mask;
  assign out_o.dot_round    = out_res.dot_round;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the serial seven-segment display multiplexer.
module tb_top;
  import ssm_pkg::*;

  localparam int unsigned NDISP        = MAX_DISPLAYS;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          PHASE_ITEMS  = 345;

  typedef enum bit {
    MODE_EDGE,
    MODE_TICK
  } item_mode_e;

  typedef struct {
    item_mode_e mode;
    bit         din;
    bit         known;
    result_t    word;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  ssm_in_if  in_ch ();
  ssm_out_if out_ch ();

  seven_segment_serial_multiplexer #(
    .NUM_DISPLAYS(NDISP)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Shadow copy of the display state.
  logic [7:0] timeout_cfg;
  logic       rx_active;
  logic [4:0] frame_acc;
  logic [2:0] frame_pos;
  logic [3:0] digit_mem [NDISP];
  logic [3:0] dot_mask;
  logic [2:0] rx_digits;
  logic [7:0] ticks_remaining;
  logic [3:0] glyph_ptr;

  result_t expected_words [$];
  int      error_count;
  int      items_sent;
  int      quiet_cycles;
  bit      steady;

  // After reset the store reads 1 8 2 1, so the first four scans show 1, 2, 8, then 1 again.
  // Then open reception, send a dotted out-of-range frame, a dotted 9 and a 0, and time out.
  stim_row_t directed_rows [25] = '{
    '{MODE_TICK, 1'b0, 1'b1, '{4'd1, 4'b1001, 1'b0}},
    '{MODE_TICK, 1'b1, 1'b1, '{4'd2, 4'b0010, 1'b0}},
    '{MODE_TICK, 1'b0, 1'b1, '{4'd8, 4'b0100, 1'b0}},
    '{MODE_TICK, 1'b1, 1'b1, '{4'd1, 4'b1001, 1'b0}},
    '{MODE_EDGE, 1'b1, 1'b0, '0},
    '{MODE_EDGE, 1'b0, 1'b0, '0},
    '{MODE_EDGE, 1'b1, 1'b0, '0},
    '{MODE_EDGE, 1'b0, 1'b0, '0},
    '{MODE_EDGE, 1'b1, 1'b0, '0},
    '{MODE_EDGE, 1'b1, 1'b0, '0},
    '{MODE_EDGE, 1'b1, 1'b0, '0},
    '{MODE_EDGE, 1'b0, 1'b0, '0},
    '{MODE_EDGE, 1'b0, 1'b0, '0},
    '{MODE_EDGE, 1'b1, 1'b0, '0},
    '{MODE_EDGE, 1'b1, 1'b0, '0},
    '{MODE_EDGE, 1'b0, 1'b0, '0},
    '{MODE_EDGE, 1'b0, 1'b0, '0},
    '{MODE_EDGE, 1'b0, 1'b0, '0},
    '{MODE_EDGE, 1'b0, 1'b0, '0},
    '{MODE_EDGE, 1'b0, 1'b0, '0},
    '{MODE_TICK, 1'b0, 1'b0, '0},
    '{MODE_TICK, 1'b1, 1'b0, '0},
    '{MODE_TICK, 1'b0, 1'b0, '0},
    '{MODE_TICK, 1'b1, 1'b0, '0},
    '{MODE_TICK, 1'b0, 1'b0, '0}
  };

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic bit predict_word(input item_mode_e mode, input bit din,
                                      output result_t word);
    logic [3:0] hits;
    word = '0;
    if (mode == MODE_EDGE) begin
      if (!rx_active) begin
        // Opening edge: its data bit is dropped.
        rx_active       = 1'b1;
        ticks_remaining = timeout_cfg;
        rx_digits       = '0;
        dot_mask        = '0;
        frame_pos       = '0;
        frame_acc       = '0;
      end else begin
        if (din) frame_acc[frame_pos] = 1'b1;
        frame_pos       = frame_pos + 3'd1;
        ticks_remaining = timeout_cfg;
        if (frame_pos > FRAME_LAST_BIT) begin
          if (frame_acc[4]) dot_mask[rx_digits[1:0]] = 1'b1;
          if (frame_acc[3:0] < DIGIT_LIMIT) begin
            digit_mem[rx_digits[1:0]] = frame_acc[3:0];
            rx_digits = rx_digits + 3'd1;
          end
          frame_acc = '0;
          frame_pos = '0;
          if (rx_digits >= NDISP) begin
            rx_active       = 1'b0;
            ticks_remaining = '0;
          end
        end
      end
      return 1'b0;
    end
    if (rx_active) begin
      ticks_remaining = ticks_remaining - 8'd1;
      if (ticks_remaining == 8'd0) begin
        rx_active = 1'b0;
        dot_mask  = 4'b0001;
      end
      return 1'b0;
    end
    for (int step = 0; step < SEARCH_STEPS; step++) begin
      if (glyph_ptr >= GLYPH_DOT_ROUND) begin
        glyph_ptr = '0;
        if (dot_mask != '0) begin
          word.glyph        = GLYPH_BLANK;
          word.display_mask = dot_mask;
          word.dot_round    = 1'b1;
          return 1'b1;
        end
      end else begin
        hits = '0;
        for (int i = 0; i < NDISP; i++)
          if (digit_mem[i] == glyph_ptr) hits[NDISP-1-i] = 1'b1;
        word.glyph = glyph_ptr;
        glyph_ptr  = glyph_ptr + 4'd1;
        if (hits != '0) begin
          word.display_mask = hits;
          word.dot_round    = 1'b0;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic send_item(input item_mode_e mode, input bit din, input bit known = 1'b0,
                           input result_t typed = '0);
    result_t word;
    bit      produced;
    while (!steady && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.data_bit <= din;
    do @(posedge clk_i); while (!in_ch.ready);
    produced = predict_word(mode, din, word);
    if (known) expected_words.push_back(typed);
    else if (produced) expected_words.push_back(word);
    items_sent++;
  endtask

  // Shift out count bits of a frame, LSB first.
  task automatic send_bits(input logic [4:0] value, input int count);
    for (int b = 0; b < count; b++) send_item(MODE_EDGE, value[b]);
  endtask

  task automatic write_timeout(input logic [7:0] value);
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    // Let a search that finds nothing run out before touching the register.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_cfg = value;
  endtask

  task automatic run_random(input int budget);
    int         start;
    int         choice;
    int         nframes;
    int         seq_idx;
    logic [4:0] value;
    start   = items_sent;
    seq_idx = 0;
    while (items_sent - start < budget) begin
      choice = $urandom_range(99);
      if (choice < 65) begin
        if (!rx_active) send_item(MODE_EDGE, 1'($urandom_range(1)));
        nframes = ($urandom_range(99) < 60) ? 4 : $urandom_range(1, 4);
        for (int k = 0; k < nframes && rx_active; k++) begin
          if ($urandom_range(99) < 75)
            value = {1'($urandom_range(99) < 30), 4'($urandom_range(9))};
          else
            value = 5'($urandom_range(10, 31));
          send_bits(value, 5);
        end
        if (rx_active && $urandom_range(99) < 20)
          send_bits(5'($urandom_range(31)), $urandom_range(1, 4));
        // Run the timeout out: always when it is short, else on a phase's first sequence and now and then at random.
        if (rx_active && ((timeout_cfg != 8'd0 && timeout_cfg <= 8'd8) || seq_idx == 0 ||
                          $urandom_range(99) < 5))
          while (rx_active) send_item(MODE_TICK, 1'($urandom_range(1)));
        repeat ($urandom_range(1, 12)) send_item(MODE_TICK, 1'($urandom_range(1)));
      end else if (choice < 85) begin
        repeat ($urandom_range(1, 6)) send_item(MODE_TICK, 1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(1, 8))
          send_item(item_mode_e'($urandom_range(1)), 1'($urandom_range(1)));
      end
      seq_idx++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with none expected: glyph %0d, mask %b, dot round %0d",
               out_ch.glyph, out_ch.display_mask, out_ch.dot_round);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_ch.glyph !== want.glyph) begin
          $error("glyph: expected %0d, got %0d", want.glyph, out_ch.glyph);
          error_count++;
        end
        if (out_ch.display_mask !== want.display_mask) begin
          $error("display_mask: expected %b, got %b", want.display_mask, out_ch.display_mask);
          error_count++;
        end
        if (out_ch.dot_round !== want.dot_round) begin
          $error("dot_round: expected %0d, got %0d", want.dot_round, out_ch.dot_round);
          error_count++;
        end
      end
    end
  end

  // Stall the result side at random, except in the steady stretch.
  always @(posedge clk_i) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 15);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [7:0] phase_timeouts [5];
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = 1'b0;
    in_ch.data_bit = 1'b0;
    out_ch.ready   = 1'b0;
    steady         = 1'b0;
    error_count    = 0;
    items_sent     = 0;
    quiet_cycles   = 0;

    timeout_cfg     = TIMEOUT_RESET;
    rx_active       = 1'b0;
    frame_acc       = '0;
    frame_pos       = '0;
    for (int i = 0; i < NDISP; i++) digit_mem[i] = DIGITS_RESET[i];
    dot_mask        = '0;
    rx_digits       = '0;
    ticks_remaining = '0;
    glyph_ptr       = '0;

    phase_timeouts = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(2, 254)), TIMEOUT_RESET};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r])
      send_item(directed_rows[r].mode, directed_rows[r].din, directed_rows[r].known,
                directed_rows[r].word);

    foreach (phase_timeouts[p]) begin
      write_timeout(phase_timeouts[p]);
      steady = (p == 0);
      run_random(PHASE_ITEMS);
    end
    steady = 1'b0;

    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
